[hdl/sg_pkg.sv]
package sg_pkg;

   // Field widths
   localparam int Z_BITS           = 16;
   localparam int Y_BITS           = 1;
   localparam int P_BITS           = 5;
   localparam int THETA_BITS       = 5;
   localparam int CARDINALITY_BITS = 7;
   localparam int REDUCT_BITS      = 4;
   localparam int INFO_BITS        = 5;
   localparam int KIND_BITS        = 2;
   localparam int ITER_BITS        = 6;
   localparam int REM_BITS         = 5;
   localparam int MOD_BITS         = ITER_BITS + CARDINALITY_BITS;
   localparam int TABLE_DEPTH      = 1 << THETA_BITS;

   // Configuration port
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 6;

   // Request function codes
   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_TABLE  = 1'b1;

   // Run length bookkeeping
   localparam int RUN_BITS = 6;
   localparam logic [RUN_BITS-1:0] MAX_RESULTS  = RUN_BITS'(34);
   localparam logic [RUN_BITS-1:0] RUN_LAST_IDX = RUN_BITS'(33);

   // Iteration cap and register reset values
   localparam logic [ITER_BITS-1:0] ITER_CAP       = ITER_BITS'(32);
   localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(16);
   localparam logic [REM_BITS-1:0]  REM_SIZE_RESET = REM_BITS'(16);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_Y      = 2'd0,
      KIND_Z      = 2'd1,
      KIND_Z_LAST = 2'd2,
      KIND_BYPASS = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAX_ITER = 1'b0,
      CSR_REM_SIZE = 1'b1
   } csr_idx_type;

endpackage

[hdl/sg_if.sv]
interface sg_req_if import sg_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [Y_BITS-1:0]           y;
   logic [P_BITS-1:0]           p_id;
   logic [Z_BITS-1:0]           z;
   logic [THETA_BITS-1:0]       theta_sel;
   logic [REDUCT_BITS-1:0]      rem_trim;
   logic                        eob;
   logic [CARDINALITY_BITS-1:0] card_value;

   modport source (output valid, func, y, p_id, z, theta_sel, rem_trim,
                   eob, card_value, input ready);
   modport sink   (input valid, func, y, p_id, z, theta_sel, rem_trim,
                   eob, card_value, output ready);
endinterface

interface sg_rsp_if import sg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [Z_BITS-1:0]    subsymbol;
   logic [INFO_BITS-1:0] info;
   kind_type             kind;
   logic                 block_end;
   logic                 last_of_run;

   modport source (output valid, subsymbol, info, kind, block_end, last_of_run,
                   input ready);
   modport sink   (input valid, subsymbol, info, kind, block_end, last_of_run,
                   output ready);
endinterface

[hdl/subsymbol_generator.sv]
// Subsymbol generator.
// req_chan takes one request per handshake. func 1 writes a cardinality into the
// per-theta table and produces nothing; func 0 encodes one symbol into a run of
// subsymbols on rsp_chan: Y, an optional BYPASS when z reaches the escape
// threshold, then Z subsymbols ending in Z_LAST, which carries last_of_run.
// csr_we/csr_index/csr_wdata write max_iterations (index 0) and remainder_size
// (index 1); write them only while no request is in progress.
// An encode request reads the table as it is taken, then passes through the
// threshold multiply, then produces one subsymbol per cycle while rsp_chan has
// room, out of the single subtract-compare unit that walks the remaining module
// down by the cardinality. req_chan.ready is high only between requests.
// Results pass through a one-deep output register, so the next request is
// taken while the final subsymbol still waits on rsp_chan. A stall on
// rsp_chan.ready holds the sequencer in place with no loss.
// Reset clears the sequencer, the output valid and the registers to 16/16;
// the cardinality table is not cleared and must be written before use.
module subsymbol_generator import sg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   sg_req_if.sink                   req_chan,
   sg_rsp_if.source                 rsp_chan,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MULT = 5'b00010,
      ST_Y    = 5'b00100,
      ST_BYP  = 5'b01000,
      ST_ZRUN = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [ITER_BITS-1:0] max_iter_ff;
   logic [REM_BITS-1:0]  rem_size_ff;

   // Cardinality table and its registered read
   logic [CARDINALITY_BITS-1:0] card_mem [TABLE_DEPTH];
   logic [CARDINALITY_BITS-1:0] card_rd_ff;

   // Captured request fields
   logic [Y_BITS-1:0]      y_ff;
   logic [P_BITS-1:0]      p_ff;
   logic [Z_BITS-1:0]      z_ff;
   logic [THETA_BITS-1:0]  theta_ff;
   logic [REDUCT_BITS-1:0] reduct_ff;
   logic                   eob_ff;

   // Working registers
   logic [MOD_BITS-1:0]         max_mod_ff, max_mod_in;
   logic [CARDINALITY_BITS-1:0] ans_ff, ans_in;
   logic [Z_BITS-1:0]           module_ff, module_in;
   logic [RUN_BITS-1:0]         cnt_ff, cnt_in;

   // Output register
   logic                 rsp_valid_ff;
   logic [Z_BITS-1:0]    rsp_sub_ff;
   logic [INFO_BITS-1:0] rsp_info_ff;
   kind_type             rsp_kind_ff;
   logic                 rsp_be_ff;
   logic                 rsp_last_ff;

   // Result being emitted this cycle
   logic                 emit;
   logic [Z_BITS-1:0]    e_sub;
   logic [INFO_BITS-1:0] e_info;
   kind_type             e_kind;
   logic                 e_be;
   logic                 e_last;

   logic                        req_acc;
   logic                        slot_free;
   logic [ITER_BITS-1:0]        iters;
   logic                        escape;
   logic [Z_BITS:0]             diff;
   logic                        stop;
   logic [CARDINALITY_BITS-1:0] card_mask;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign iters     = (max_iter_ff > ITER_CAP) ? ITER_CAP : max_iter_ff;
   assign escape    = (z_ff >= Z_BITS'(max_mod_ff));
   assign card_mask = card_rd_ff - CARDINALITY_BITS'(1);

   // Shared subtract-compare: stop when the remaining module is not above ans, or at the run's last index
   assign diff = {1'b0, module_ff} - (Z_BITS+1)'(ans_ff);
   assign stop = diff[Z_BITS] || (diff[Z_BITS-1:0] == '0) || (cnt_ff == RUN_LAST_IDX);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      max_mod_in = max_mod_ff;
      ans_in     = ans_ff;
      module_in  = module_ff;
      cnt_in     = cnt_ff;
      emit       = 1'b0;
      e_sub      = '0;
      e_info     = '0;
      e_kind     = KIND_Y;
      e_be       = 1'b0;
      e_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_chan.func == FUNC_ENCODE)) begin
               state_in = ST_MULT;
               cnt_in   = '0;
            end
         end
         ST_MULT: begin
            max_mod_in = MOD_BITS'(iters) * MOD_BITS'(card_rd_ff);
            state_in   = ST_Y;
         end
         ST_Y: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_sub  = Z_BITS'(y_ff);
               e_info = INFO_BITS'(p_ff);
               e_kind = KIND_Y;
               if (escape) begin
                  ans_in    = card_rd_ff;
                  module_in = Z_BITS'(max_mod_ff);
                  state_in  = ST_BYP;
               end else begin
                  ans_in    = z_ff[CARDINALITY_BITS-1:0] & card_mask;
                  module_in = z_ff;
                  state_in  = ST_ZRUN;
               end
            end
         end
         ST_BYP: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_sub    = z_ff;
               e_info   = INFO_BITS'(rem_size_ff - REM_BITS'(reduct_ff));
               e_kind   = KIND_BYPASS;
               state_in = ST_ZRUN;
            end
         end
         ST_ZRUN: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_info = INFO_BITS'(theta_ff);
               if (stop) begin
                  e_sub    = module_ff;
                  e_kind   = KIND_Z_LAST;
                  e_be     = eob_ff;
                  e_last   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  e_sub     = Z_BITS'(ans_ff);
                  e_kind    = KIND_Z;
                  module_in = diff[Z_BITS-1:0];
                  ans_in    = card_rd_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit) begin
         cnt_in = cnt_ff + RUN_BITS'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= MAX_ITER_RESET;
         rem_size_ff  <= REM_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_ITER: max_iter_ff <= csr_wdata[ITER_BITS-1:0];
               CSR_REM_SIZE: rem_size_ff <= csr_wdata[REM_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Table: write on func 1 requests, read on every accepted request
   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (req_chan.func == FUNC_TABLE) begin
            card_mem[req_chan.theta_sel] <= req_chan.card_value;
         end
         card_rd_ff <= card_mem[req_chan.theta_sel];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         y_ff      <= req_chan.y;
         p_ff      <= req_chan.p_id;
         z_ff      <= req_chan.z;
         theta_ff  <= req_chan.theta_sel;
         reduct_ff <= req_chan.rem_trim;
         eob_ff    <= req_chan.eob;
      end
      max_mod_ff <= max_mod_in;
      ans_ff     <= ans_in;
      module_ff  <= module_in;
      cnt_ff     <= cnt_in;
      if (emit) begin
         rsp_sub_ff  <= e_sub;
         rsp_info_ff <= e_info;
         rsp_kind_ff <= e_kind;
         rsp_be_ff   <= e_be;
         rsp_last_ff <= e_last;
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.subsymbol    = rsp_sub_ff;
   assign rsp_chan.info         = rsp_info_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.block_end    = rsp_be_ff;
   assign rsp_chan.last_of_run  = rsp_last_ff;

   // Only the closing Z_LAST marks the end of a run
   a_last_is_zlast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == KIND_Z_LAST)))
      else $error("last_of_run does not match Z_LAST");

   // Block end only rides on Z_LAST
   a_be_on_zlast: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_be_ff) |-> (rsp_kind_ff == KIND_Z_LAST))
      else $error("block_end on a non-final subsymbol");

   // Run never exceeds the result guard
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= MAX_RESULTS))
      else $error("run longer than the result guard");

   // An encode request starts with the threshold multiply
   a_encode_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_chan.func == FUNC_ENCODE)) |=> (state_ff == ST_MULT))
      else $error("encode request did not start the sequencer");

endmodule

[verif/tb_subsymbol_generator.sv]
module tb_subsymbol_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import sg_pkg::*;

   localparam int   WATCHDOG_LIMIT  = 2000;
   localparam int   SETTLE_CYCLES   = 8;
   localparam int   END_CYCLES      = 24;
   localparam int   HOLD_OFF_CYCLES = 80;
   localparam int   IDLE_PERCENT    = 27;

   typedef struct {
      logic                        func;
      logic [Y_BITS-1:0]           y;
      logic [P_BITS-1:0]           p_id;
      logic [Z_BITS-1:0]           z;
      logic [THETA_BITS-1:0]       theta_sel;
      logic [REDUCT_BITS-1:0]      rem_trim;
      logic                        eob;
      logic [CARDINALITY_BITS-1:0] card_value;
   } symbol_req_type;

   typedef struct {
      logic [Z_BITS-1:0]    subsymbol;
      logic [INFO_BITS-1:0] info;
      kind_type             kind;
      logic                 block_end;
      logic                 last_of_run;
   } subsymbol_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   sg_req_if req_chan ();
   sg_rsp_if rsp_chan ();

   subsymbol_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's table and registers
   logic [CARDINALITY_BITS-1:0] card_table [TABLE_DEPTH];
   logic [ITER_BITS-1:0]        max_iter;
   logic [REM_BITS-1:0]         rem_size;
   subsymbol_type               expected_subsymbols [$];

   bit idling_on     = 1'b1;
   int rsp_hold_left = 0;
   int quiet_cycles  = 0;
   int mismatches    = 0;
   int symbols_sent  = 0;
   int table_writes  = 0;
   int escapes       = 0;
   int longest_run   = 0;
   int checked       = 0;
   int settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void push_expected(input logic [Z_BITS-1:0] value,
                                         input logic [INFO_BITS-1:0] info,
                                         input kind_type kind, input logic block_end,
                                         input logic last_of_run);
      subsymbol_type s;
      s.subsymbol   = value;
      s.info        = info;
      s.kind        = kind;
      s.block_end   = block_end;
      s.last_of_run = last_of_run;
      expected_subsymbols.push_back(s);
   endfunction

   // Escape threshold: capped iteration count times the stored cardinality
   function automatic logic [MOD_BITS-1:0] escape_threshold(input logic [THETA_BITS-1:0] theta);
      logic [MOD_BITS-1:0] iters;
      iters = (max_iter > ITER_CAP) ? MOD_BITS'(ITER_CAP) : MOD_BITS'(max_iter);
      return iters * MOD_BITS'(card_table[theta]);
   endfunction

   // Expand one symbol into its run of subsymbols
   function automatic void predict_symbol(input symbol_req_type r);
      logic [MOD_BITS-1:0] threshold;
      logic [Z_BITS-1:0]   card;
      logic [Z_BITS-1:0]   step;
      logic [Z_BITS-1:0]   remaining;
      int                  count;
      card      = Z_BITS'(card_table[r.theta_sel]);
      threshold = escape_threshold(r.theta_sel);
      push_expected(Z_BITS'(r.y), INFO_BITS'(r.p_id), KIND_Y, 1'b0, 1'b0);
      count = 1;
      if (r.z >= Z_BITS'(threshold)) begin
         push_expected(r.z, INFO_BITS'(rem_size - REM_BITS'(r.rem_trim)),
                       KIND_BYPASS, 1'b0, 1'b0);
         step      = card;
         remaining = Z_BITS'(threshold);
         count++;
         escapes++;
      end else begin
         step      = r.z & (card - 1'b1);
         remaining = r.z;
      end
      // walk the module down; the run is cut short at its length limit
      while (step < remaining && count < int'(MAX_RESULTS) - 1) begin
         remaining -= step;
         push_expected(step, INFO_BITS'(r.theta_sel), KIND_Z, 1'b0, 1'b0);
         step = card;
         count++;
      end
      push_expected(remaining, INFO_BITS'(r.theta_sel), KIND_Z_LAST, r.eob, 1'b1);
      count++;
      if (count > longest_run)
         longest_run = count;
   endfunction

   function automatic logic [CARDINALITY_BITS-1:0] random_card();
      if ($urandom_range(0, 9) < 6)
         return CARDINALITY_BITS'(1) << $urandom_range(0, 6);
      return CARDINALITY_BITS'($urandom_range(0, 127));
   endfunction

   function automatic symbol_req_type table_request(input int theta,
                                                    input logic [CARDINALITY_BITS-1:0] card);
      symbol_req_type r;
      r.func       = FUNC_TABLE;
      r.y          = Y_BITS'($urandom);
      r.p_id       = P_BITS'($urandom);
      r.z          = Z_BITS'($urandom);
      r.theta_sel  = THETA_BITS'(theta);
      r.rem_trim   = REDUCT_BITS'($urandom);
      r.eob        = 1'($urandom);
      r.card_value = card;
      return r;
   endfunction

   function automatic symbol_req_type encode_request(input int y, input int p_id, input int z,
                                                     input int theta, input int reduct,
                                                     input int eob);
      symbol_req_type r;
      r.func       = FUNC_ENCODE;
      r.y          = Y_BITS'(y);
      r.p_id       = P_BITS'(p_id);
      r.z          = Z_BITS'(z);
      r.theta_sel  = THETA_BITS'(theta);
      r.rem_trim   = REDUCT_BITS'(reduct);
      r.eob        = 1'(eob);
      r.card_value = CARDINALITY_BITS'($urandom);
      return r;
   endfunction

   // Random symbol with z mostly steered around the escape threshold, plus small and full-range values
   function automatic symbol_req_type random_symbol();
      int theta;
      int limit;
      int z;
      int pick;
      theta = $urandom_range(0, TABLE_DEPTH - 1);
      limit = int'(escape_threshold(THETA_BITS'(theta)));
      pick  = $urandom_range(0, 9);
      if (pick < 4)
         z = $urandom_range(0, limit + limit / 4);
      else if (pick < 6)
         z = (limit >= 2) ? $urandom_range(limit - 2, limit + 2) : $urandom_range(0, 3);
      else if (pick < 8)
         z = $urandom_range(0, 15);
      else
         z = $urandom_range(0, 65535);
      return encode_request($urandom, $urandom, z, theta, $urandom,
                            $urandom_range(0, 4) == 0);
   endfunction

   function automatic symbol_req_type random_request();
      if ($urandom_range(0, 9) == 0)
         return table_request($urandom_range(0, TABLE_DEPTH - 1), random_card());
      return random_symbol();
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic send_request(input symbol_req_type r);
      if (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= r.func;
      req_chan.y          <= r.y;
      req_chan.p_id       <= r.p_id;
      req_chan.z          <= r.z;
      req_chan.theta_sel  <= r.theta_sel;
      req_chan.rem_trim   <= r.rem_trim;
      req_chan.eob        <= r.eob;
      req_chan.card_value <= r.card_value;
      do @(posedge clock); while (!req_chan.ready);
      if (r.func == FUNC_TABLE) begin
         card_table[r.theta_sel] = r.card_value;
         table_writes++;
      end else begin
         predict_symbol(r);
         symbols_sent++;
      end
   endtask

   // Drop the request line and wait for every outstanding subsymbol
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_subsymbols.size() != 0);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_BITS-1:0] iter_data,
                                  input logic [CSR_DATA_BITS-1:0] rem_data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_ITER;
      csr_wdata <= iter_data;
      @(posedge clock);
      csr_index <= CSR_REM_SIZE;
      csr_wdata <= rem_data;
      @(posedge clock);
      csr_we   <= 1'b0;
      max_iter = ITER_BITS'(iter_data);
      rem_size = REM_BITS'(rem_data);
      settings_used++;
   endtask

   // Fill every table entry, with zero, odd and largest cardinalities among them
   task automatic test_table_load();
      logic [CARDINALITY_BITS-1:0] card;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (i)
            0:       card = 7'd1;
            1:       card = 7'd0;
            2:       card = 7'd3;
            3:       card = 7'd127;
            4:       card = 7'd64;
            31:      card = 7'd64;
            default: card = random_card();
         endcase
         send_request(table_request(i, card));
      end
   endtask

   // Field extremes, escape boundaries, zero and odd cardinalities
   task automatic test_directed_symbols();
      send_request(encode_request(0, 0, 0, 0, 0, 0));
      send_request(encode_request(1, 31, 15, 0, 15, 1));
      send_request(encode_request(0, 5, 16, 0, 3, 0));
      send_request(encode_request(1, 1, 0, 1, 0, 0));
      send_request(encode_request(0, 2, 65535, 1, 15, 1));
      send_request(encode_request(0, 3, 47, 2, 0, 0));
      send_request(encode_request(1, 4, 48, 2, 7, 0));
      send_request(encode_request(0, 6, 2, 2, 0, 1));
      send_request(encode_request(1, 7, 2031, 3, 0, 0));
      send_request(encode_request(0, 8, 2032, 3, 8, 1));
      send_request(encode_request(1, 9, 100, 3, 0, 0));
      send_request(encode_request(0, 10, 1023, 4, 0, 0));
      send_request(encode_request(1, 11, 1024, 4, 15, 0));
      send_request(encode_request(0, 12, 65535, 4, 0, 1));
      send_request(encode_request(1, 31, 65535, 31, 15, 1));
      send_request(encode_request(0, 31, 0, 31, 0, 0));
      send_request(encode_request(1, 16, 16'hAAAA, 30, 10, 0));
      send_request(encode_request(0, 15, 16'h5555, 30, 5, 1));
   endtask

   // Register extremes: zero and capped iterations, remainder width wrap
   task automatic test_register_settings();
      int k;
      for (k = 0; k < 7; k++) begin
         case (k)
            0:       write_registers(6'd0, 6'd0);
            1:       write_registers(6'd1, 6'd63);
            2:       write_registers(6'd32, 6'd5);
            3:       write_registers(6'd33, 6'd32);
            4:       write_registers(6'd63, 6'd31);
            5:       write_registers(6'd8, 6'd20);
            default: write_registers(CSR_DATA_BITS'(MAX_ITER_RESET),
                                     CSR_DATA_BITS'(REM_SIZE_RESET));
         endcase
         repeat (12) send_request(random_request());
      end
   endtask

   // Hold the result side off so the block backs up into its input
   task automatic test_output_stall();
      rsp_hold_left = HOLD_OFF_CYCLES;
      repeat (12) send_request(random_symbol());
      wait_drained();
   endtask

   // Pause the sender until the block has emptied, then resume
   task automatic test_drain_pause();
      repeat (8) send_request(random_request());
      wait_drained();
      repeat (8) send_request(random_request());
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      repeat (60) send_request(random_request());
      idling_on = 1'b1;
   endtask

   task automatic test_random_mix();
      repeat (4) begin
         write_registers(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom));
         repeat (20) send_request(random_request());
      end
   endtask

   // Result side: random idling plus the long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left--;
      end else if (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each accepted subsymbol with the oldest expectation
   always @(posedge clock) begin
      subsymbol_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_subsymbols.size() == 0) begin
            report_mismatch("subsymbol with none expected", rsp_chan.subsymbol, 0);
         end else begin
            want = expected_subsymbols.pop_front();
            checked++;
            if (rsp_chan.subsymbol !== want.subsymbol)
               report_mismatch("subsymbol", rsp_chan.subsymbol, want.subsymbol);
            if (rsp_chan.info !== want.info)
               report_mismatch("info", rsp_chan.info, want.info);
            if (rsp_chan.kind !== want.kind)
               report_mismatch("kind", rsp_chan.kind, want.kind);
            if (rsp_chan.block_end !== want.block_end)
               report_mismatch("block_end", rsp_chan.block_end, want.block_end);
            if (rsp_chan.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_chan.last_of_run, want.last_of_run);
         end
      end
   end

   // Abort when no handshake or register write happens for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d subsymbols outstanding",
                  quiet_cycles, expected_subsymbols.size());
         $display("subsymbol_generator: mismatch");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_MAX_ITER;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FUNC_ENCODE;
      req_chan.y          <= '0;
      req_chan.p_id       <= '0;
      req_chan.z          <= '0;
      req_chan.theta_sel  <= '0;
      req_chan.rem_trim   <= '0;
      req_chan.eob        <= 1'b0;
      req_chan.card_value <= '0;
      max_iter = MAX_ITER_RESET;
      rem_size = REM_SIZE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_table_load();
      test_directed_symbols();
      test_register_settings();
      test_output_stall();
      test_drain_pause();
      test_steady_stream();
      test_random_mix();

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      $display("Run covered %0d symbols (%0d escaping) and %0d table writes, %0d subsymbols",
               symbols_sent, escapes, table_writes, checked);
      $display("over %0d register settings; longest run %0d subsymbols, %0d mismatches",
               settings_used, longest_run, mismatches);
      if (mismatches == 0)
         $display("subsymbol_generator: match");
      else
         $display("subsymbol_generator: mismatch");
      $finish;
   end

endmodule
